@@ sv/rsc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the RPN stack calculator.
// No dependencies; imported by every module of the block.
package rsc_pkg;

   localparam int DATA_W          = 32;
   localparam int FRAC_W          = 16;
   localparam int DEPTH_W         = 5;
   localparam int STATUS_W        = 2;
   localparam int STACK_DEPTH_DEF = 16;

   localparam logic REQ_PUSH  = 1'b0;
   localparam logic REQ_APPLY = 1'b1;

   localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FEW  = 2'd1,
      ST_FULL = 2'd2,
      ST_DIV0 = 2'd3
   } status_type;

   typedef struct packed {
      logic                     start;
      op_type                   op;
      logic signed [DATA_W-1:0] first;
      logic signed [DATA_W-1:0] second;
   } arith_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] value;
   } arith_rsp_type;

endpackage

@@ sv/rsc_stack_ram.sv @@
`timescale 1ns / 1ps
// Operand store: one write port, one read port with registered data.
// Depends on rsc_pkg.
module rsc_stack_ram import rsc_pkg::*; #(
   parameter int DEPTH = STACK_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic signed [DATA_W-1:0]   wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic signed [DATA_W-1:0]   rd_data
);

   logic signed [DATA_W-1:0] store_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rsc_arith.sv @@
`timescale 1ns / 1ps
// Saturating Q16.16 arithmetic: registered add/sub, two-stage multiply,
// radix-2 restoring divide. Depends on rsc_pkg.
module rsc_arith import rsc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  arith_req_type arith_req,
   output arith_rsp_type arith_rsp
);

   localparam int CNT_W = $clog2(DATA_W);

   typedef enum logic [3:0] {
      A_IDLE = 4'b0001,
      A_MUL  = 4'b0010,
      A_DIV  = 4'b0100,
      A_FIN  = 4'b1000
   } arith_state_type;

   arith_state_type            state_ff, state_in;
   logic                       done_ff, done_in;
   logic signed [DATA_W-1:0]   value_ff, value_in;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic [DATA_W:0]            rem_ff, rem_in;
   logic [DATA_W-1:0]          dvd_ff, dvd_in;
   logic [DATA_W-1:0]          dvs_ff, dvs_in;
   logic [DATA_W-1:0]          quo_ff, quo_in;
   logic                       neg_ff, neg_in;
   logic                       ovf_ff, ovf_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;

   logic signed [DATA_W:0]       sum_w, dif_w;
   logic [DATA_W-1:0]            abs_f, abs_s;
   logic [2*DATA_W-FRAC_W-1:0]   mq;
   logic                         mq_adj;
   logic [DATA_W:0]              shifted;
   logic [DATA_W+1:0]            trial;
   logic [DATA_W-1:0]            neg_q;

   function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [DATA_W:0] v);
      if (v[DATA_W] != v[DATA_W-1]) begin
         return v[DATA_W] ? VAL_MIN : VAL_MAX;
      end
      return v[DATA_W-1:0];
   endfunction

   always_comb begin
      sum_w   = {arith_req.first[DATA_W-1], arith_req.first}
              + {arith_req.second[DATA_W-1], arith_req.second};
      dif_w   = {arith_req.first[DATA_W-1], arith_req.first}
              - {arith_req.second[DATA_W-1], arith_req.second};
      abs_f   = arith_req.first[DATA_W-1] ? (~arith_req.first + 1'b1) : arith_req.first;
      abs_s   = arith_req.second[DATA_W-1] ? (~arith_req.second + 1'b1) : arith_req.second;
      mq_adj  = prod_ff[2*DATA_W-1] && (prod_ff[FRAC_W-1:0] != '0);
      mq      = prod_ff[2*DATA_W-1:FRAC_W] + {{(2*DATA_W-FRAC_W-1){1'b0}}, mq_adj};
      shifted = {rem_ff[DATA_W-1:0], dvd_ff[DATA_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      neg_q   = ~quo_ff + 1'b1;

      state_in = state_ff;
      done_in  = 1'b0;
      value_in = value_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;

      unique case (state_ff)
         A_IDLE: begin
            if (arith_req.start) begin
               case (arith_req.op)
                  OP_ADD: begin
                     value_in = sat_wide(sum_w);
                     done_in  = 1'b1;
                  end
                  OP_SUB: begin
                     value_in = sat_wide(dif_w);
                     done_in  = 1'b1;
                  end
                  OP_MUL: begin
                     prod_in  = arith_req.first * arith_req.second;
                     state_in = A_MUL;
                  end
                  default: begin
                     ovf_in   = {{FRAC_W{1'b0}}, abs_f[DATA_W-1:FRAC_W]} >= abs_s;
                     rem_in   = {{(FRAC_W+1){1'b0}}, abs_f[DATA_W-1:FRAC_W]};
                     dvd_in   = {abs_f[FRAC_W-1:0], {(DATA_W-FRAC_W){1'b0}}};
                     dvs_in   = abs_s;
                     quo_in   = '0;
                     neg_in   = arith_req.first[DATA_W-1] ^ arith_req.second[DATA_W-1];
                     cnt_in   = '0;
                     state_in = ovf_in ? A_FIN : A_DIV;
                  end
               endcase
            end
         end
         A_MUL: begin
            if (mq[2*DATA_W-FRAC_W-1:DATA_W-1] == '0 ||
                mq[2*DATA_W-FRAC_W-1:DATA_W-1] == '1) begin
               value_in = mq[DATA_W-1:0];
            end else begin
               value_in = mq[2*DATA_W-FRAC_W-1] ? VAL_MIN : VAL_MAX;
            end
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         A_DIV: begin
            if (!trial[DATA_W+1]) begin
               rem_in = trial[DATA_W:0];
            end else begin
               rem_in = shifted;
            end
            quo_in = {quo_ff[DATA_W-2:0], !trial[DATA_W+1]};
            dvd_in = {dvd_ff[DATA_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DATA_W-1)) begin
               state_in = A_FIN;
            end
         end
         A_FIN: begin
            if (neg_ff) begin
               value_in = (ovf_ff || (quo_ff[DATA_W-1] && quo_ff[DATA_W-2:0] != '0))
                        ? VAL_MIN : neg_q;
            end else begin
               value_in = (ovf_ff || quo_ff[DATA_W-1]) ? VAL_MAX : quo_ff;
            end
            done_in  = 1'b1;
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
      cnt_ff   <= cnt_in;
   end

   assign arith_rsp.done  = done_ff;
   assign arith_rsp.value = value_ff;

endmodule

@@ sv/rpn_stack_calculator.sv @@
`timescale 1ns / 1ps
// RPN stack calculator top: control, top-of-stack register, result register.
// Push, too few operands, full stack, divide by zero: result valid the cycle after accept.
// Add/sub, multiply and divide pass S_READ, S_CALC, then S_WB (divide: 32-step loop).
// Pushes go one per cycle while results are taken; an operation holds input until its result.
// Reset empties the stack and drops any pending result; the store itself is not cleared.
module rpn_stack_calculator import rsc_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic signed [DATA_W-1:0] req_operand_value,
   input  logic [1:0]               req_op_code,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_top_value,
   output logic [DEPTH_W-1:0]       rsp_stack_depth,
   output logic [STATUS_W-1:0]      rsp_status
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CALC = 4'b0100,
      S_WB   = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [DATA_W-1:0] top_ff, top_in;
   op_type                   op_ff, op_in;
   logic signed [DATA_W-1:0] second_ff, second_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_top_ff, rsp_top_in;
   logic [DEPTH_W-1:0]       rsp_depth_ff, rsp_depth_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic                     slot_free, req_fire, full, few;
   logic [CW-1:0]            cnt_m1, cnt_m2;
   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic signed [DATA_W-1:0] wr_data, rd_data;
   arith_req_type            arith_req;
   arith_rsp_type            arith_rsp;

   function automatic logic [DEPTH_W-1:0] depth_field(input logic [CW-1:0] c);
      logic [CW+DEPTH_W-1:0] w;
      w = {{DEPTH_W{1'b0}}, c};
      return w[DEPTH_W-1:0];
   endfunction

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign full      = count_ff == CW'(STACK_DEPTH);
   assign few       = count_ff < CW'(2);
   assign cnt_m1    = count_ff - CW'(1);
   assign cnt_m2    = count_ff - CW'(2);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      top_in           = top_ff;
      op_in            = op_ff;
      second_in        = second_ff;
      res_in           = res_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_top_in       = rsp_top_ff;
      rsp_depth_in     = rsp_depth_ff;
      rsp_status_in    = rsp_status_ff;
      wr_en            = 1'b0;
      wr_addr          = cnt_m2[AW-1:0];
      wr_data          = res_ff;
      rd_en            = 1'b0;
      rd_addr          = cnt_m2[AW-1:0];
      arith_req.start  = 1'b0;
      arith_req.op     = op_ff;
      arith_req.first  = rd_data;
      arith_req.second = second_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in = 1'b1;
               rsp_top_in   = (count_ff == '0) ? '0 : top_ff;
               rsp_depth_in = depth_field(count_ff);
               if (req_type == REQ_PUSH) begin
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     wr_addr       = count_ff[AW-1:0];
                     wr_data       = req_operand_value;
                     count_in      = count_ff + CW'(1);
                     top_in        = req_operand_value;
                     rsp_top_in    = req_operand_value;
                     rsp_depth_in  = depth_field(count_ff + CW'(1));
                     rsp_status_in = ST_OK;
                  end
               end else if (few) begin
                  rsp_status_in = ST_FEW;
               end else if (op_type'(req_op_code) == OP_DIV && top_ff == '0) begin
                  rsp_status_in = ST_DIV0;
               end else begin
                  rsp_valid_in = 1'b0;
                  rd_en        = 1'b1;
                  op_in        = op_type'(req_op_code);
                  second_in    = top_ff;
                  state_in     = S_READ;
               end
            end
         end
         S_READ: begin
            arith_req.start = 1'b1;
            state_in        = S_CALC;
         end
         S_CALC: begin
            if (arith_rsp.done) begin
               res_in   = arith_rsp.value;
               state_in = S_WB;
            end
         end
         S_WB: begin
            if (slot_free) begin
               wr_en         = 1'b1;
               count_in      = cnt_m1;
               top_in        = res_ff;
               rsp_valid_in  = 1'b1;
               rsp_top_in    = res_ff;
               rsp_depth_in  = depth_field(cnt_m1);
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      op_ff         <= op_in;
      second_ff     <= second_in;
      res_ff        <= res_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   rsc_stack_ram #(
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rsc_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .arith_req (arith_req),
      .arith_rsp (arith_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_stack_depth = rsp_depth_ff;
   assign rsp_status      = rsp_status_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("control state not one-hot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("entry count beyond stack depth");

   a_read_two: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> count_ff >= CW'(2))
      else $error("operand read with fewer than two entries");

   a_done_calc: assert property (@(posedge clock) disable iff (reset)
      arith_rsp.done |-> state_ff == S_CALC)
      else $error("arithmetic result outside calc state");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_type == REQ_PUSH && !full |=> count_ff == $past(count_ff) + CW'(1))
      else $error("push did not grow the stack");

   a_wb_shrinks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WB && slot_free |=> rsp_valid && count_ff == $past(count_ff) - CW'(1))
      else $error("write-back did not pop and report");

endmodule

@@ tb/sv/tb_rpn_stack_calculator.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for rpn_stack_calculator: directed and random push/operation
// streams with a transaction-level stack predictor. Depends on rsc_pkg and the block's RTL.
module tb_rpn_stack_calculator;
   import rsc_pkg::*;

   localparam int RSP_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 64;
   localparam int CYCLE_LIMIT     = 1_000_000;

   typedef struct {
      logic signed [DATA_W-1:0] top;
      logic [DEPTH_W-1:0]       depth;
      status_type               status;
   } stack_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_type = REQ_PUSH;
   logic signed [DATA_W-1:0] req_operand_value = '0;
   logic [1:0]               req_op_code = OP_ADD;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_top_value;
   logic [DEPTH_W-1:0]       rsp_stack_depth;
   logic [STATUS_W-1:0]      rsp_status;

   logic signed [DATA_W-1:0] shadow_stack [STACK_DEPTH_DEF];
   int                       shadow_count = 0;
   stack_result_type         results_due [$];
   stack_result_type         due_result;

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_rsp = 1'b0;
   int   error_count = 0;
   int   cycle_count = 0;

   rpn_stack_calculator i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_operand_value (req_operand_value),
      .req_op_code       (req_op_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_top_value     (rsp_top_value),
      .rsp_stack_depth   (rsp_stack_depth),
      .rsp_status        (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [DATA_W-1:0] saturate(longint v);
      if (v > longint'(VAL_MAX)) return VAL_MAX;
      if (v < longint'(VAL_MIN)) return VAL_MIN;
      return v[DATA_W-1:0];
   endfunction

   function automatic stack_result_type evaluate_rpn_step(logic kind,
                                                          logic signed [DATA_W-1:0] operand,
                                                          op_type op);
      stack_result_type r;
      longint           first;
      longint           second;
      longint           acc;
      r.status = ST_OK;
      if (kind == REQ_PUSH) begin
         if (shadow_count >= STACK_DEPTH_DEF) begin
            r.status = ST_FULL;
         end else begin
            shadow_stack[shadow_count] = operand;
            shadow_count++;
         end
      end else if (shadow_count < 2) begin
         r.status = ST_FEW;
      end else begin
         first  = shadow_stack[shadow_count-2];
         second = shadow_stack[shadow_count-1];
         if (op == OP_DIV && second == 0) begin
            r.status = ST_DIV0;
         end else begin
            case (op)
               OP_ADD: acc = first + second;
               OP_SUB: acc = first - second;
               OP_MUL: acc = (first * second) / 64'sd65536;
               default: acc = (first * 64'sd65536) / second;
            endcase
            shadow_stack[shadow_count-2] = saturate(acc);
            shadow_count--;
         end
      end
      r.top   = (shadow_count > 0) ? shadow_stack[shadow_count-1] : '0;
      r.depth = shadow_count[DEPTH_W-1:0];
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] random_operand();
      case ($urandom_range(0, 9)) inside
         0: return '0;
         1: return VAL_MAX;
         2: return VAL_MIN;
         3, 4: return $urandom;
         default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      endcase
   endfunction

   // Call right after a rising edge; returns at the edge that accepts the transaction.
   task automatic send_item(logic kind, logic signed [DATA_W-1:0] operand, op_type op);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_operand_value <= operand;
      req_op_code       <= op;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      results_due.push_back(evaluate_rpn_step(kind, operand, op));
   endtask

   task automatic push_operand(logic signed [DATA_W-1:0] operand);
      send_item(REQ_PUSH, operand, op_type'($urandom_range(0, 3)));
   endtask

   task automatic apply_op(op_type op);
      send_item(REQ_APPLY, $urandom, op);
   endtask

   task automatic report_mismatch(string field, longint due, longint got);
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, due, got);
   endtask

   // Compare each accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            report_mismatch("unexpected transaction, depth", -1, rsp_stack_depth);
         end else begin
            due_result = results_due.pop_front();
            if (rsp_top_value !== due_result.top)
               report_mismatch("top_value", due_result.top, rsp_top_value);
            if (rsp_stack_depth !== due_result.depth)
               report_mismatch("stack_depth", due_result.depth, rsp_stack_depth);
            if (rsp_status !== due_result.status)
               report_mismatch("status", due_result.status, rsp_status);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic test_too_few_operands();
      apply_op(OP_ADD);
      push_operand(VAL_MAX);
      apply_op(OP_SUB);
   endtask

   task automatic test_saturation();
      push_operand(VAL_MAX);
      apply_op(OP_ADD);
      push_operand(VAL_MAX);
      apply_op(OP_MUL);
      push_operand(VAL_MIN);
      apply_op(OP_SUB);
      push_operand(VAL_MIN);
      push_operand(VAL_MIN);
      apply_op(OP_ADD);
      push_operand(32'sd1);
      apply_op(OP_DIV);
      push_operand(-32'sd1);
      apply_op(OP_DIV);
      apply_op(OP_SUB);
   endtask

   task automatic test_divide_by_zero();
      push_operand('0);
      apply_op(OP_DIV);
      apply_op(OP_MUL);
   endtask

   task automatic test_truncation();
      push_operand(-32'sd3);
      push_operand(32'sh0000_8000);
      apply_op(OP_MUL);
      push_operand(32'sh0002_0000);
      apply_op(OP_DIV);
   endtask

   // Hold off results so the block backs up, then overfill the stack.
   task automatic test_full_stack_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_rsp = 1'b1;
      repeat (STACK_DEPTH_DEF + 4) push_operand(random_operand());
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      int push_pct;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) begin
         if (shadow_count < 2) push_pct = 85;
         else if (shadow_count >= STACK_DEPTH_DEF - 1) push_pct = 35;
         else push_pct = 50;
         if ($urandom_range(0, 99) < push_pct) push_operand(random_operand());
         else apply_op(op_type'($urandom_range(0, 3)));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_too_few_operands();
      test_saturation();
      test_divide_by_zero();
      test_truncation();
      test_full_stack_backpressure();
      test_random(260, 0, 0);
      test_random(260, 70, 0);
      test_random(260, 0, 70);
      test_random(260, 11, 11);
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (results_due.size() != 0) error_count++;
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
sv/rsc_pkg.sv
sv/rsc_stack_ram.sv
sv/rsc_arith.sv
sv/rpn_stack_calculator.sv
tb/sv/tb_rpn_stack_calculator.sv
